// ===== hdl/i2cbm_pkg.sv =====
// i2cbm_pkg: shared types and constants for the i2c bit-level master
// no dependencies; imported by i2cbm_phase and i2c_bit_level_master_top
`default_nettype none

package i2cbm_pkg;

    localparam int BYTE_BITS = 8;
    localparam int HOLD_W    = 8;
    localparam int PHASE_W   = 5;
    localparam int BIT_W     = $clog2(BYTE_BITS);

    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(4);

    localparam logic [PHASE_W-1:0] START_LAST = PHASE_W'(3);
    localparam logic [PHASE_W-1:0] STOP_LAST  = PHASE_W'(2);
    localparam logic [PHASE_W-1:0] SEND_BITS  = PHASE_W'(3 * BYTE_BITS);
    localparam logic [PHASE_W-1:0] SEND_LAST  = PHASE_W'(3 * BYTE_BITS + 1);
    localparam logic [PHASE_W-1:0] RECV_LAST  = PHASE_W'(2 * BYTE_BITS);
    localparam logic [PHASE_W-1:0] SACK_LAST  = PHASE_W'(2);
    localparam logic [PHASE_W-1:0] CHK_LAST   = PHASE_W'(1);

    typedef enum logic [2:0] {
        FUNC_START   = 3'd0,
        FUNC_STOP    = 3'd1,
        FUNC_SEND    = 3'd2,
        FUNC_RECV    = 3'd3,
        FUNC_SACK    = 3'd4,
        FUNC_CHK_ACK = 3'd5
    } t_func;

    typedef struct packed {
        logic scl;
        logic sda;
        logic delay;
        logic rx_en;
        logic ack_en;
        logic last;
    } t_phase;

endpackage

`default_nettype wire

// ===== hdl/i2cbm_phase.sv =====
// i2cbm_phase: pin assignment for one phase of the current bus command
// depends on i2cbm_pkg
`default_nettype none

module i2cbm_phase
    import i2cbm_pkg::*;
(
    input  wire logic [2:0]           i_func,
    input  wire logic [PHASE_W-1:0]   i_phase,
    input  wire logic [1:0]           i_sub,
    input  wire logic [BIT_W-1:0]     i_bit,
    input  wire logic [BYTE_BITS-1:0] i_tx_data,
    input  wire logic                 i_ack_out,
    input  wire logic                 i_scl_level,
    input  wire logic                 i_sda_level,
    output t_phase                    o_phase
);

    logic [BIT_W-1:0] tx_idx;

    assign tx_idx = BIT_W'(BYTE_BITS - 1) - i_bit;

    always_comb begin
        o_phase = '0;
        o_phase.scl = i_scl_level;
        o_phase.sda = i_sda_level;
        unique case (t_func'(i_func))
            FUNC_START: begin
                unique case (i_phase[1:0])
                    2'd0: begin
                        o_phase.sda = 1'b1;
                    end
                    2'd1: begin
                        o_phase = '{scl: 1'b1, sda: 1'b1, delay: 1'b1, default: 1'b0};
                    end
                    2'd2: begin
                        o_phase = '{scl: 1'b1, sda: 1'b0, delay: 1'b1, default: 1'b0};
                    end
                    default: begin
                        o_phase = '{last: (i_phase == START_LAST), default: 1'b0};
                    end
                endcase
            end
            FUNC_STOP: begin
                unique case (i_phase[1:0])
                    2'd0: begin
                        o_phase.sda = 1'b0;
                    end
                    2'd1: begin
                        o_phase = '{scl: 1'b1, sda: 1'b0, delay: 1'b1, default: 1'b0};
                    end
                    default: begin
                        o_phase = '{scl: 1'b1, sda: 1'b1, delay: 1'b1,
                                    last: (i_phase == STOP_LAST), default: 1'b0};
                    end
                endcase
            end
            FUNC_SEND: begin
                if (i_phase >= SEND_BITS) begin
                    o_phase.scl    = (i_phase != SEND_LAST);
                    o_phase.delay  = 1'b1;
                    o_phase.ack_en = (i_phase == SEND_LAST);
                    o_phase.last   = (i_phase == SEND_LAST);
                end else begin
                    case (i_sub)
                        2'd0: begin
                            o_phase.sda = i_tx_data[tx_idx];
                        end
                        2'd1: begin
                            o_phase.scl   = 1'b1;
                            o_phase.delay = 1'b1;
                        end
                        default: begin
                            o_phase.scl   = 1'b0;
                            o_phase.delay = 1'b1;
                        end
                    endcase
                end
            end
            FUNC_RECV: begin
                if (i_phase == '0) begin
                    o_phase.sda = 1'b1;
                end else begin
                    o_phase.scl   = i_phase[0];
                    o_phase.delay = 1'b1;
                    o_phase.rx_en = (i_phase == RECV_LAST);
                    o_phase.last  = (i_phase == RECV_LAST);
                end
            end
            FUNC_SACK: begin
                if (i_phase == '0) begin
                    o_phase.sda = i_ack_out;
                end else begin
                    o_phase.scl   = (i_phase != SACK_LAST);
                    o_phase.delay = 1'b1;
                    o_phase.last  = (i_phase == SACK_LAST);
                end
            end
            FUNC_CHK_ACK: begin
                o_phase.scl    = (i_phase != CHK_LAST);
                o_phase.delay  = 1'b1;
                o_phase.ack_en = (i_phase == CHK_LAST);
                o_phase.last   = (i_phase == CHK_LAST);
            end
            default: begin
                o_phase.last = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/i2c_bit_level_master_top.sv =====
// i2c_bit_level_master_top: bit-level i2c master, one bus command per request
// depends on i2cbm_pkg and i2cbm_phase
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------------------
//  in       | sink      | i_in_valid / o_in_stall | i_func i_tx_data i_ack_out i_bus_bits
//           |           |                         | i_bus_ack
//  out      | source    | o_out_valid/i_out_stall | o_scl_out o_sda_out o_hold_len
//           |           |                         | o_rx_byte o_ack_seen o_last
//  cfg      | sink      | i_cfg_wr_en             | i_cfg_wr_data (hold_units)
//
// one result per cycle from the phase sequencer while out is not stalled; each command emits its
// sequence of pin phases, the last flagged by o_last; codes 6 and 7 emit nothing.
// a request is registered into the command registers, then its first phase into the out registers.
// the next request is taken in the same cycle as the current command's last phase is registered.
// a stall on out freezes the sequencer; reset leaves both lines high, hold 4.
`default_nettype none

module i2c_bit_level_master_top
    import i2cbm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [2:0]           i_func,
    input  wire logic [BYTE_BITS-1:0] i_tx_data,
    input  wire logic                 i_ack_out,
    input  wire logic [BYTE_BITS-1:0] i_bus_bits,
    input  wire logic                 i_bus_ack,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_scl_out,
    output logic                      o_sda_out,
    output logic [HOLD_W-1:0]         o_hold_len,
    output logic [BYTE_BITS-1:0]      o_rx_byte,
    output logic                      o_ack_seen,
    output logic                      o_last,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [HOLD_W-1:0]    i_cfg_wr_data
);

    logic                 r_busy;
    logic [2:0]           r_func;
    logic [BYTE_BITS-1:0] r_tx_data;
    logic                 r_ack_out;
    logic [BYTE_BITS-1:0] r_bus_bits;
    logic                 r_bus_ack;
    logic [PHASE_W-1:0]   r_phase;
    logic [1:0]           r_sub;
    logic [BIT_W-1:0]     r_bit;
    logic                 r_scl;
    logic                 r_sda;
    logic [HOLD_W-1:0]    r_hold;

    logic [1:0]           n_sub;
    logic [BIT_W-1:0]     n_bit;

    t_phase ph;
    logic   adv;
    logic   take;
    logic   func_ok;

    i2cbm_phase u_phase (
        .i_func      (r_func),
        .i_phase     (r_phase),
        .i_sub       (r_sub),
        .i_bit       (r_bit),
        .i_tx_data   (r_tx_data),
        .i_ack_out   (r_ack_out),
        .i_scl_level (r_scl),
        .i_sda_level (r_sda),
        .o_phase     (ph)
    );

    assign adv        = r_busy && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_busy && !(adv && ph.last);
    assign take       = i_in_valid && !o_in_stall;
    assign func_ok    = (i_func <= 3'(FUNC_CHK_ACK));

    always_comb begin
        if (r_sub == 2'd2) begin
            n_sub = 2'd0;
            n_bit = r_bit + BIT_W'(1);
        end else begin
            n_sub = r_sub + 2'd1;
            n_bit = r_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_busy <= func_ok;
        end else if (adv && ph.last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_func     <= i_func;
            r_tx_data  <= i_tx_data;
            r_ack_out  <= i_ack_out;
            r_bus_bits <= i_bus_bits;
            r_bus_ack  <= i_bus_ack;
            r_phase    <= '0;
            r_sub      <= '0;
            r_bit      <= '0;
        end else if (adv) begin
            r_phase <= r_phase + PHASE_W'(1);
            r_sub   <= n_sub;
            r_bit   <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl  <= 1'b1;
            r_sda  <= 1'b1;
            r_hold <= HOLD_RESET;
        end else begin
            if (adv) begin
                r_scl <= ph.scl;
                r_sda <= ph.sda;
            end
            if (i_cfg_wr_en) begin
                r_hold <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_scl_out  <= ph.scl;
            o_sda_out  <= ph.sda;
            o_hold_len <= ph.delay ? r_hold : '0;
            o_rx_byte  <= ph.rx_en ? r_bus_bits : '0;
            o_ack_seen <= ph.ack_en & r_bus_ack;
            o_last     <= ph.last;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/i2c_bit_level_master_top_test.sv =====
// i2c_bit_level_master_top_test: self-checking bench for the i2c bit-level master
// depends on i2cbm_pkg and i2c_bit_level_master_top; predicts every pin phase of
// each bus command and checks it against the result stream under random stalls
module i2c_bit_level_master_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbm_pkg::*;

    localparam logic [2:0] FUNC_RSVD_A  = 3'd6;
    localparam logic [2:0] FUNC_RSVD_B  = 3'd7;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         ITEMS_PER_HOLD = 30;

    typedef struct packed {
        logic [2:0]           func;
        logic [BYTE_BITS-1:0] tx_data;
        logic                 ack_out;
        logic [BYTE_BITS-1:0] bus_bits;
        logic                 bus_ack;
    } t_bus_cmd;

    typedef struct packed {
        logic                 scl;
        logic                 sda;
        logic [HOLD_W-1:0]    hold;
        logic [BYTE_BITS-1:0] rx;
        logic                 ack;
        logic                 last;
    } t_pin_phase;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [2:0]           i_func;
    logic [BYTE_BITS-1:0] i_tx_data;
    logic                 i_ack_out;
    logic [BYTE_BITS-1:0] i_bus_bits;
    logic                 i_bus_ack;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_scl_out;
    logic                 o_sda_out;
    logic [HOLD_W-1:0]    o_hold_len;
    logic [BYTE_BITS-1:0] o_rx_byte;
    logic                 o_ack_seen;
    logic                 o_last;
    logic                 i_cfg_wr_en;
    logic [HOLD_W-1:0]    i_cfg_wr_data;

    t_pin_phase        phase_q[$];
    logic              line_scl;
    logic              line_sda;
    logic [HOLD_W-1:0] hold_cfg;
    int                err_cnt = 0;
    int                bus_cmd_cnt = 0;
    bit                idle_en = 1'b1;
    int                hold_off_cycles = 0;

    i2c_bit_level_master_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_tx_data     (i_tx_data),
        .i_ack_out     (i_ack_out),
        .i_bus_bits    (i_bus_bits),
        .i_bus_ack     (i_bus_ack),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_scl_out     (o_scl_out),
        .o_sda_out     (o_sda_out),
        .o_hold_len    (o_hold_len),
        .o_rx_byte     (o_rx_byte),
        .o_ack_seen    (o_ack_seen),
        .o_last        (o_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("** i2c_bit_level_master_top: FAILED **");
        $finish;
    end

    // pin phase predictor
    function automatic void add_phase(logic scl, logic sda, logic dly);
        t_pin_phase p;
        line_scl = scl;
        line_sda = sda;
        p.scl    = scl;
        p.sda    = sda;
        p.hold   = dly ? hold_cfg : '0;
        p.rx     = '0;
        p.ack    = 1'b0;
        p.last   = 1'b0;
        phase_q.push_back(p);
    endfunction

    function automatic void predict_pin_phases(t_bus_cmd c);
        t_pin_phase p;
        case (c.func)
            FUNC_START: begin
                add_phase(line_scl, 1'b1, 1'b0);
                add_phase(1'b1, 1'b1, 1'b1);
                add_phase(1'b1, 1'b0, 1'b1);
                add_phase(1'b0, 1'b0, 1'b0);
            end
            FUNC_STOP: begin
                add_phase(line_scl, 1'b0, 1'b0);
                add_phase(1'b1, 1'b0, 1'b1);
                add_phase(1'b1, 1'b1, 1'b1);
            end
            FUNC_SEND: begin
                for (int i = BYTE_BITS - 1; i >= 0; i--) begin
                    add_phase(line_scl, c.tx_data[i], 1'b0);
                    add_phase(1'b1, line_sda, 1'b1);
                    add_phase(1'b0, line_sda, 1'b1);
                end
                add_phase(1'b1, line_sda, 1'b1);
                add_phase(1'b0, line_sda, 1'b1);
            end
            FUNC_RECV: begin
                add_phase(line_scl, 1'b1, 1'b0);
                for (int i = 0; i < BYTE_BITS; i++) begin
                    add_phase(1'b1, line_sda, 1'b1);
                    add_phase(1'b0, line_sda, 1'b1);
                end
            end
            FUNC_SACK: begin
                add_phase(line_scl, c.ack_out, 1'b0);
                add_phase(1'b1, line_sda, 1'b1);
                add_phase(1'b0, line_sda, 1'b1);
            end
            FUNC_CHK_ACK: begin
                add_phase(1'b1, line_sda, 1'b1);
                add_phase(1'b0, line_sda, 1'b1);
            end
            default: return;
        endcase
        p = phase_q.pop_back();
        p.last = 1'b1;
        if (c.func == FUNC_SEND || c.func == FUNC_CHK_ACK)
            p.ack = c.bus_ack;
        if (c.func == FUNC_RECV)
            p.rx = c.bus_bits;
        phase_q.push_back(p);
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_pin_phase want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (phase_q.size() == 0) begin
                $display("%0t: unexpected result scl=%0b sda=%0b hold=%0h rx=%0h ack=%0b last=%0b",
                         $time, o_scl_out, o_sda_out, o_hold_len, o_rx_byte, o_ack_seen,
                         o_last);
                err_cnt++;
            end else begin
                want = phase_q.pop_front();
                check_field("scl_out", 8'(want.scl), 8'(o_scl_out));
                check_field("sda_out", 8'(want.sda), 8'(o_sda_out));
                check_field("hold_len", want.hold, o_hold_len);
                check_field("rx_byte", want.rx, o_rx_byte);
                check_field("ack_seen", 8'(want.ack), 8'(o_ack_seen));
                check_field("last", 8'(want.last), 8'(o_last));
            end
        end
    end

    // result side stall pattern, plus long hold-off on request
    initial begin : out_stall_gen
        int run;
        int r;
        run = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
                i_out_stall <= 1'b0;
            end else if (!idle_en) begin
                i_out_stall <= 1'b0;
            end else if (run > 0) begin
                run--;
                i_out_stall <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    run = 0;
                else if (r < 90)
                    run = $urandom_range(1, 3);
                else if (r < 98)
                    run = $urandom_range(4, 10);
                else
                    run = $urandom_range(15, 30);
                i_out_stall <= (run > 0);
                if (run > 0)
                    run--;
            end
        end
    end

    function automatic t_bus_cmd rand_cmd(logic [2:0] f);
        t_bus_cmd c;
        c.func     = f;
        c.tx_data  = 8'($urandom);
        c.ack_out  = 1'($urandom);
        c.bus_bits = 8'($urandom);
        c.bus_ack  = 1'($urandom);
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    task automatic send_cmd(t_bus_cmd c);
        i_func     <= c.func;
        i_tx_data  <= c.tx_data;
        i_ack_out  <= c.ack_out;
        i_bus_bits <= c.bus_bits;
        i_bus_ack  <= c.bus_ack;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_pin_phases(c);
        if (c.func != FUNC_RSVD_A && c.func != FUNC_RSVD_B)
            bus_cmd_cnt++;
    endtask

    task automatic issue(t_bus_cmd c);
        int n;
        send_cmd(c);
        n = idle_en ? pick_gap() : 0;
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic issue_fields(logic [2:0] f, logic [7:0] tx, logic ack_o,
                                logic [7:0] bits, logic ack_b);
        t_bus_cmd c;
        c.func     = f;
        c.tx_data  = tx;
        c.ack_out  = ack_o;
        c.bus_bits = bits;
        c.bus_ack  = ack_b;
        issue(c);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (phase_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_commands();
        issue_fields(FUNC_STOP,    8'h00, 1'b0, 8'h00, 1'b0);
        issue_fields(FUNC_START,   8'hff, 1'b1, 8'hff, 1'b1);
        issue_fields(FUNC_SEND,    8'h00, 1'b0, 8'hff, 1'b0);
        issue_fields(FUNC_SEND,    8'hff, 1'b1, 8'h00, 1'b1);
        issue_fields(FUNC_SEND,    8'ha5, 1'b0, 8'h5a, 1'b0);
        issue_fields(FUNC_SEND,    8'h5a, 1'b1, 8'ha5, 1'b1);
        issue_fields(FUNC_RECV,    8'hff, 1'b1, 8'h00, 1'b1);
        issue_fields(FUNC_RECV,    8'h00, 1'b0, 8'hff, 1'b0);
        issue_fields(FUNC_RECV,    8'h3c, 1'b1, 8'ha5, 1'b0);
        issue_fields(FUNC_SACK,    8'h00, 1'b0, 8'h00, 1'b1);
        issue_fields(FUNC_SACK,    8'hff, 1'b1, 8'hff, 1'b0);
        issue_fields(FUNC_CHK_ACK, 8'h00, 1'b1, 8'h00, 1'b0);
        issue_fields(FUNC_CHK_ACK, 8'hff, 1'b0, 8'hff, 1'b1);
        // reserved codes leave the bus untouched
        issue_fields(FUNC_RSVD_A,  8'hff, 1'b1, 8'hff, 1'b1);
        issue_fields(FUNC_RSVD_B,  8'h00, 1'b0, 8'h00, 1'b0);
        issue_fields(FUNC_START,   8'h81, 1'b0, 8'h7e, 1'b1);
        issue_fields(FUNC_STOP,    8'h00, 1'b0, 8'h00, 1'b0);
        issue_fields(FUNC_STOP,    8'hff, 1'b1, 8'hff, 1'b1);
        issue_fields(FUNC_START,   8'h00, 1'b0, 8'h00, 1'b0);
        issue_fields(FUNC_START,   8'hff, 1'b1, 8'hff, 1'b1);
        issue_fields(FUNC_RSVD_B,  8'hff, 1'b1, 8'hff, 1'b1);
        issue_fields(FUNC_STOP,    8'h0f, 1'b1, 8'hf0, 1'b0);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        t_bus_cmd c;
        idle_en = 1'b0;
        hold_off_cycles = 200;
        issue(rand_cmd(FUNC_START));
        for (int k = 0; k < 10; k++) begin
            c = rand_cmd(3'($urandom_range(0, 5)));
            issue(c);
        end
        issue(rand_cmd(FUNC_STOP));
        wait_idle();
        idle_en = 1'b1;
    endtask

    task automatic test_hold_setting(logic [HOLD_W-1:0] units, bit with_idle);
        t_bus_cmd c;
        int stop_at;
        int nbytes;
        logic rd;
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= units;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        hold_cfg = units;
        idle_en = with_idle;
        stop_at = bus_cmd_cnt + ITEMS_PER_HOLD;
        while (bus_cmd_cnt < stop_at) begin
            if ($urandom_range(0, 9) < 8) begin
                // well-formed transfer: start, address, data bytes, and in most transfers a stop
                issue(rand_cmd(FUNC_START));
                c = rand_cmd(FUNC_SEND);
                c.bus_ack = ($urandom_range(0, 7) == 0);
                rd = c.tx_data[0];
                issue(c);
                nbytes = $urandom_range(1, 4);
                for (int k = 0; k < nbytes; k++) begin
                    if (rd) begin
                        issue(rand_cmd(FUNC_RECV));
                        c = rand_cmd(FUNC_SACK);
                        c.ack_out = (k == nbytes - 1);
                        issue(c);
                    end else begin
                        c = rand_cmd(FUNC_SEND);
                        c.bus_ack = ($urandom_range(0, 7) == 0);
                        issue(c);
                    end
                end
                if ($urandom_range(0, 4) != 0)
                    issue(rand_cmd(FUNC_STOP));
            end else begin
                issue(rand_cmd(3'($urandom_range(0, 7))));
            end
        end
        wait_idle();
        idle_en = 1'b1;
    endtask

    initial begin
        line_scl = 1'b1;
        line_sda = 1'b1;
        hold_cfg = HOLD_RESET;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_func        <= FUNC_START;
        i_tx_data     <= '0;
        i_ack_out     <= 1'b0;
        i_bus_bits    <= '0;
        i_bus_ack     <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_commands();
        test_output_backpressure();
        test_hold_setting(8'd1, 1'b1);
        test_hold_setting(8'd255, 1'b1);
        test_hold_setting(8'd0, 1'b1);
        test_hold_setting(8'($urandom_range(2, 254)), 1'b0);

        if (err_cnt == 0)
            $display("** i2c_bit_level_master_top: PASSED **");
        else
            $display("** i2c_bit_level_master_top: FAILED **");
        $finish;
    end

endmodule
